[design/key_packet_sequence_checker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the key packet sequence checker
// Shared concurrent assertion forms, one per reset handling style.
// ----------------------------------------------------------------------------
`ifndef KEY_PACKET_SEQUENCE_CHECKER_ASSERT_SVH
`define KEY_PACKET_SEQUENCE_CHECKER_ASSERT_SVH

// Checked only while out of reset.
`define KPSC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("kpsc assertion failed");

// Checked at every edge, reset included.
`define KPSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kpsc assertion failed");

`endif

[design/kpsc_pkg.sv]
// ----------------------------------------------------------------------------
// kpsc_pkg
// Types and codes shared by the key packet sequence checker modules.
// ----------------------------------------------------------------------------
package kpsc_pkg;

    localparam int TAG_W  = 6;
    localparam int SIG_W  = 8;
    localparam int VER_W  = 8;
    localparam int KIND_W = 3;
    localparam int PH_W   = 3;
    localparam int ERR_W  = 4;
    localparam int VERD_W = 2;
    localparam int WARN_W = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // packet tags
    localparam logic [TAG_W-1:0] TAG_SIG        = 6'd2;
    localparam logic [TAG_W-1:0] TAG_SEC_KEY    = 6'd5;
    localparam logic [TAG_W-1:0] TAG_PUB_KEY    = 6'd6;
    localparam logic [TAG_W-1:0] TAG_SEC_SUBKEY = 6'd7;
    localparam logic [TAG_W-1:0] TAG_UID        = 6'd13;
    localparam logic [TAG_W-1:0] TAG_PUB_SUBKEY = 6'd14;
    localparam logic [TAG_W-1:0] TAG_ATTR       = 6'd17;

    // signature types
    localparam logic [SIG_W-1:0] SIG_CERT_LO    = 8'h10;
    localparam logic [SIG_W-1:0] SIG_CERT_HI    = 8'h13;
    localparam logic [SIG_W-1:0] SIG_BINDING    = 8'h18;
    localparam logic [SIG_W-1:0] SIG_KEY_REVOKE = 8'h20;
    localparam logic [SIG_W-1:0] SIG_SUB_REVOKE = 8'h28;
    localparam logic [SIG_W-1:0] SIG_UID_REVOKE = 8'h30;

    localparam logic [VER_W-1:0] KEY_V3 = 8'd3;

    localparam logic [KIND_W-1:0] KIND_PUBLIC  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PRIVATE = 3'd1;

    // sequence phases
    localparam logic [PH_W-1:0] PH_KEY    = 3'd0;
    localparam logic [PH_W-1:0] PH_REVOKE = 3'd1;
    localparam logic [PH_W-1:0] PH_USER   = 3'd2;
    localparam logic [PH_W-1:0] PH_SUBKEY = 3'd3;
    localparam logic [PH_W-1:0] PH_FAIL   = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE        = 4'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_TYPE    = 4'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_FEW     = 4'd2;
    localparam logic [ERR_W-1:0] ERR_FIRST_NOKEY = 4'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_KEY_SIG = 4'd4;
    localparam logic [ERR_W-1:0] ERR_NOT_USER    = 4'd5;
    localparam logic [ERR_W-1:0] ERR_BAD_USR_SIG = 4'd6;
    localparam logic [ERR_W-1:0] ERR_NO_UID      = 4'd7;
    localparam logic [ERR_W-1:0] ERR_BAD_SUBKEY  = 4'd8;
    localparam logic [ERR_W-1:0] ERR_V3_SUBKEY   = 4'd9;
    localparam logic [ERR_W-1:0] ERR_NO_BINDING  = 4'd10;

    localparam logic [VERD_W-1:0] VERD_OPEN   = 2'd0;
    localparam logic [VERD_W-1:0] VERD_ACCEPT = 2'd1;
    localparam logic [VERD_W-1:0] VERD_REJECT = 2'd2;

    localparam logic [WARN_W-1:0] WARN_NONE   = 2'd0;
    localparam logic [WARN_W-1:0] WARN_KEY    = 2'd1;
    localparam logic [WARN_W-1:0] WARN_UID    = 2'd2;
    localparam logic [WARN_W-1:0] WARN_SUBKEY = 2'd3;

    typedef struct packed {
        logic             last;
        logic [VER_W-1:0] key_version;
        logic [SIG_W-1:0] sig_type;
        logic [TAG_W-1:0] packet_tag;
    } pkt_t;

    typedef struct packed {
        logic [WARN_W-1:0] revocation_warning;
        logic [ERR_W-1:0]  error_code;
        logic [VERD_W-1:0] verdict;
    } res_t;

endpackage

[design/kpsc_in_reg.sv]
// ----------------------------------------------------------------------------
// kpsc_in_reg
// Input register: captures one slave request per cycle while s_tready is high.
// ----------------------------------------------------------------------------
module kpsc_in_reg
    import kpsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  logic                advance,
    output logic                pkt_valid,
    output pkt_t                pkt
);

    logic valid_reg;
    logic valid_next;
    pkt_t pkt_reg;

    // stage frees up when empty or when its content moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pkt_reg.packet_tag  <= s_tdata[TAG_W-1:0];
            pkt_reg.sig_type    <= s_tdata[TAG_W+SIG_W-1:TAG_W];
            pkt_reg.key_version <= s_tdata[TAG_W+SIG_W+VER_W-1:TAG_W+SIG_W];
            pkt_reg.last        <= s_tlast;
        end
    end

    assign pkt_valid = valid_reg;
    assign pkt       = pkt_reg;

endmodule

[design/kpsc_check.sv]
// ----------------------------------------------------------------------------
// kpsc_check
// Sequence state and grammar check, one packet per cycle while step is high.
// ----------------------------------------------------------------------------
`include "key_packet_sequence_checker_assert.svh"

module kpsc_check
    import kpsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [KIND_W-1:0] kind,
    input  logic              step,
    input  pkt_t              pkt,
    output res_t              res
);

    logic [PH_W-1:0]  phase_reg,   phase_next;
    logic             v3_reg,      v3_next;
    logic             saw_uid_reg, saw_uid_next;
    logic             cur_uid_reg, cur_uid_next;
    logic             binding_reg, binding_next;
    logic [ERR_W-1:0] err_reg,     err_next;

    always_comb begin
        logic [ERR_W-1:0]  code;
        logic              is_user;
        logic              sub_ok;
        logic [TAG_W-1:0]  key_tag;
        logic [WARN_W-1:0] warn;

        code         = ERR_NONE;
        warn         = WARN_NONE;
        phase_next   = phase_reg;
        v3_next      = v3_reg;
        saw_uid_next = saw_uid_reg;
        cur_uid_next = cur_uid_reg;
        binding_next = binding_reg;
        is_user      = (pkt.packet_tag == TAG_UID) || (pkt.packet_tag == TAG_ATTR);
        key_tag      = (kind == KIND_PUBLIC) ? TAG_PUB_KEY : TAG_SEC_KEY;
        // unknown kinds match no subkey tag
        sub_ok = ((kind == KIND_PUBLIC)  && (pkt.packet_tag == TAG_PUB_SUBKEY)) ||
                 ((kind == KIND_PRIVATE) && (pkt.packet_tag == TAG_SEC_SUBKEY));

        case (phase_reg)
            PH_KEY: begin
                v3_next = (pkt.key_version == KEY_V3);
                if (kind != KIND_PUBLIC && kind != KIND_PRIVATE) begin
                    code = ERR_BAD_TYPE;
                end else if (pkt.last) begin
                    code = ERR_TOO_FEW;
                end else if (pkt.packet_tag != key_tag) begin
                    code = ERR_FIRST_NOKEY;
                end else begin
                    phase_next = PH_REVOKE;
                end
            end
            PH_REVOKE: begin
                if (pkt.packet_tag == TAG_SIG) begin
                    if (pkt.sig_type == SIG_KEY_REVOKE) warn = WARN_KEY;
                    else code = ERR_BAD_KEY_SIG;
                end else if (is_user) begin
                    cur_uid_next = (pkt.packet_tag == TAG_UID);
                    saw_uid_next = saw_uid_reg || (pkt.packet_tag == TAG_UID);
                    phase_next   = PH_USER;
                end else begin
                    code = ERR_NOT_USER;
                end
            end
            PH_USER: begin
                if (pkt.packet_tag == TAG_SIG) begin
                    if (pkt.sig_type >= SIG_CERT_LO && pkt.sig_type <= SIG_CERT_HI) begin
                        warn = WARN_NONE;
                    end else if (cur_uid_reg && pkt.sig_type == SIG_UID_REVOKE) begin
                        warn = WARN_UID;
                    end else begin
                        code = ERR_BAD_USR_SIG;
                    end
                end else if (is_user) begin
                    cur_uid_next = (pkt.packet_tag == TAG_UID);
                    saw_uid_next = saw_uid_reg || (pkt.packet_tag == TAG_UID);
                    phase_next   = PH_USER;
                end else if (!saw_uid_reg) begin
                    code = ERR_NO_UID;
                end else if (!sub_ok) begin
                    code = ERR_BAD_SUBKEY;
                end else if (v3_reg) begin
                    code = ERR_V3_SUBKEY;
                end else begin
                    binding_next = 1'b0;
                    phase_next   = PH_SUBKEY;
                end
            end
            PH_SUBKEY: begin
                if (pkt.packet_tag == TAG_SIG) begin
                    if (pkt.sig_type == SIG_SUB_REVOKE) warn = WARN_SUBKEY;
                    else if (pkt.sig_type == SIG_BINDING) binding_next = 1'b1;
                end else if (!binding_reg) begin
                    code = ERR_NO_BINDING;
                end else if (!sub_ok) begin
                    code = ERR_BAD_SUBKEY;
                end else if (v3_reg) begin
                    code = ERR_V3_SUBKEY;
                end else begin
                    binding_next = 1'b0;
                    phase_next   = PH_SUBKEY;
                end
            end
            default: begin
                code = ERR_NONE;
            end
        endcase

        // end-of-block checks on the phase the packet left behind
        if (code == ERR_NONE && pkt.last) begin
            if (phase_next == PH_REVOKE) code = ERR_NOT_USER;
            else if (phase_next == PH_USER && !saw_uid_next) code = ERR_NO_UID;
            else if (phase_next == PH_SUBKEY && !binding_next) code = ERR_NO_BINDING;
        end

        err_next = err_reg;
        if (code != ERR_NONE) begin
            phase_next = PH_FAIL;
            if (err_reg == ERR_NONE) err_next = code;
        end

        res.error_code         = err_next;
        res.revocation_warning = warn;
        if (err_next != ERR_NONE) res.verdict = VERD_REJECT;
        else if (pkt.last)        res.verdict = VERD_ACCEPT;
        else                      res.verdict = VERD_OPEN;

        if (pkt.last) begin
            phase_next   = PH_KEY;
            v3_next      = 1'b0;
            saw_uid_next = 1'b0;
            cur_uid_next = 1'b0;
            binding_next = 1'b0;
            err_next     = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_KEY;
            v3_reg      <= 1'b0;
            saw_uid_reg <= 1'b0;
            cur_uid_reg <= 1'b0;
            binding_reg <= 1'b0;
            err_reg     <= ERR_NONE;
        end else if (step) begin
            phase_reg   <= phase_next;
            v3_reg      <= v3_next;
            saw_uid_reg <= saw_uid_next;
            cur_uid_reg <= cur_uid_next;
            binding_reg <= binding_next;
            err_reg     <= err_next;
        end
    end

    `KPSC_ASSERT(a_err_sticky, aclk, aresetn, (step && err_reg != ERR_NONE && !pkt.last) |=> $stable(err_reg))
    `KPSC_ASSERT(a_fail_has_err, aclk, aresetn, (phase_reg == PH_FAIL) == (err_reg != ERR_NONE))
    `KPSC_ASSERT(a_last_clears, aclk, aresetn, (step && pkt.last) |=> (phase_reg == PH_KEY && err_reg == ERR_NONE && !saw_uid_reg))

endmodule

[design/kpsc_out_reg.sv]
// ----------------------------------------------------------------------------
// kpsc_out_reg
// Result register toward the master side; holds a result while stalled.
// ----------------------------------------------------------------------------
`include "key_packet_sequence_checker_assert.svh"

module kpsc_out_reg
    import kpsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  res_t                res,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic valid_reg;
    res_t res_reg;

    assign advance = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg;

    `KPSC_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

[design/key_packet_sequence_checker.sv]
// ----------------------------------------------------------------------------
// key_packet_sequence_checker
// Checks a stream of key block packet descriptors against the key grammar.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one packet request per cycle (s_tdata holds tag, signature
//   type and key version; s_tlast marks the final packet of a key block).
//   Master side returns exactly one result per packet: running verdict, first
//   latched error and a revocation warning for that packet.
//   cfg_we/cfg_wdata set the key block kind; write it only while idle.
// Throughput: one packet per cycle while m_tready is high; the whole check is
//   one pass of the phase logic between the input register and the result
//   register, which takes the result when it can advance.
// Reset (aresetn low, synchronous): pipeline empties, kind returns to public,
//   sequence state returns to "expect primary key".
// Stall: when m_tready is low the result is held; the input register still
//   takes a request only if empty, then s_tready drops until the result drains.
// State also returns to "expect primary key" after every last packet.
// ----------------------------------------------------------------------------
module key_packet_sequence_checker
    import kpsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [KIND_W-1:0]   cfg_wdata,   // key_block_kind
    input  logic                s_tvalid,
    output logic                s_tready,
    // [5:0] packet_tag, [13:6] sig_type, [21:14] key_version, [23:22] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,     // last_packet
    output logic                m_tvalid,
    input  logic                m_tready,
    // [1:0] verdict, [5:2] error_code, [7:6] revocation_warning
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [KIND_W-1:0] kind_reg;
    logic              advance;
    logic              pkt_valid;
    pkt_t              pkt;
    res_t              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_PUBLIC;
        end else if (cfg_we) begin
            kind_reg <= cfg_wdata;
        end
    end

    kpsc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .advance   (advance),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    kpsc_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .kind    (kind_reg),
        .step    (pkt_valid && advance),
        .pkt     (pkt),
        .res     (res)
    );

    kpsc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (pkt_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
